[design/ntpcf_pkg.sv]
package ntpcf_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_DRIFT_RATE = 2'd0,
    REG_PRECISION  = 2'd1,
    REG_MAX_DISP   = 2'd2
  } ntpcf_reg_t;

  localparam logic [31:0]       DRIFT_RESET     = 32'd64425;
  localparam logic signed [5:0] PRECISION_RESET = -6'sd18;
  localparam logic [31:0]       MAX_DISP_RESET  = 32'd1048576;

  // One sample tuple as held by a filter stage
  typedef struct packed {
    logic signed [47:0] offset;
    logic [31:0]        delay;
    logic [31:0]        disp;
    logic [47:0]        stime;
  } ntpcf_tuple_t;

  // Per-cycle command shared by all stage cells
  typedef struct packed {
    logic load;     // shift a new sample in, age the older stages
    logic rotate;   // circulate tuples and ranks by one stage
    logic rank_we;  // capture freshly computed ranks
  } ntpcf_cell_ctl_t;

endpackage

[design/ntp_clock_filter.sv]
// Channel  | Ports                         | Beat contents (lowest bit first)
// in       | in_tvalid/in_tready/in_tdata  | sample offset, delay, dispersion, time
// out      | out_tvalid/out_tready/out_*   | best offset, delay, peer disp, jitter; fresh
// cfg      | cfg_we/cfg_addr/cfg_wdata     | drift rate, precision exponent, max disp
//
// The square root, one result bit per cycle, and the radix-16 divide of the
// squared-offset sum take most of the time spent on one sample.
// Reset is synchronous; the stages come up holding max dispersion as empty.
// A finished result waits in the output register; the next sample is taken
// meanwhile and stalls only at hand-off if the previous beat is still held.
module ntp_clock_filter #(
  parameter int STAGES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [47:0] sample_offset, [79:48] sample_delay, [111:80] sample_dispersion,
  // [159:112] sample_time
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] best_offset, [79:48] best_delay, [111:80] peer_dispersion,
  // [143:112] peer_jitter
  output logic [143:0] out_tdata,
  // [0] fresh
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int RANK_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int CNT_W    = $clog2(STAGES + 1);
  localparam int ACC_W    = 36 + STAGES;
  localparam int SUM_W    = 64 + $clog2(STAGES);
  localparam int DIV_W    = ((SUM_W + 3) / 4) * 4;
  localparam int DIV_STEPS = DIV_W / 4;
  localparam int SQRT_STEPS = 32;
  localparam int SEQ_W    = $clog2(SQRT_STEPS + DIV_STEPS + STAGES);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_MUL1  = 11'b000_0000_0010,
    ST_MUL2  = 11'b000_0000_0100,
    ST_INC   = 11'b000_0000_1000,
    ST_LOAD  = 11'b000_0001_0000,
    ST_RANK  = 11'b000_0010_0000,
    ST_SCAN1 = 11'b000_0100_0000,
    ST_SCAN2 = 11'b000_1000_0000,
    ST_DIV   = 11'b001_0000_0000,
    ST_SQRT  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  // configuration
  logic [31:0]        drift_r;
  logic signed [5:0]  prec_r;
  logic [31:0]        maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_r <= ntpcf_pkg::DRIFT_RESET;
      prec_r  <= ntpcf_pkg::PRECISION_RESET;
      maxd_r  <= ntpcf_pkg::MAX_DISP_RESET;
    end else if (cfg_we) begin
      case (ntpcf_pkg::ntpcf_reg_t'(cfg_addr))
        ntpcf_pkg::REG_DRIFT_RATE: drift_r <= cfg_wdata;
        ntpcf_pkg::REG_PRECISION:  prec_r  <= signed'(cfg_wdata[5:0]);
        ntpcf_pkg::REG_MAX_DISP:   maxd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;

  ntpcf_pkg::ntpcf_tuple_t samp_r, samp_nxt;
  logic [47:0]  dt_r, dt_nxt;
  logic [63:0]  a_r, a_nxt;
  logic [47:0]  b_r, b_nxt;
  logic [31:0]  inc_r, inc_nxt;
  logic [47:0]  last_used_r, last_used_nxt;
  logic         has_update_r, has_update_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [47:0] best_off_r, best_off_nxt;
  logic [31:0]  best_delay_r, best_delay_nxt;
  logic [47:0]  best_time_r, best_time_nxt;
  logic [31:0]  mag_r, mag_nxt;
  logic         mv_r, mv_nxt;
  logic [63:0]  sq_r;
  logic         sv_r;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] sum_r, sum_nxt;
  logic [63:0]  res_r, res_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [143:0] out_data_r, out_data_nxt;
  logic         out_fresh_r, out_fresh_nxt;

  // stage chain
  ntpcf_pkg::ntpcf_cell_ctl_t ctl;
  ntpcf_pkg::ntpcf_tuple_t tuple_w [STAGES];
  logic [RANK_W-1:0]       rank_w  [STAGES];
  logic [RANK_W-1:0]       rank_calc [STAGES];
  ntpcf_pkg::ntpcf_tuple_t head;
  logic [RANK_W-1:0]       head_rank;

  assign head      = tuple_w[STAGES-1];
  assign head_rank = rank_w[STAGES-1];

  always_comb begin
    ctl.load    = (state_r == ST_LOAD);
    ctl.rotate  = (state_r == ST_SCAN1) ||
                  ((state_r == ST_SCAN2) && (seq_r < SEQ_W'(STAGES)));
    ctl.rank_we = (state_r == ST_RANK);
  end

  // Stable rank by delay: earlier (newer) stages win ties.
  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      logic [CNT_W-1:0] c;
      c = '0;
      for (int j = 0; j < STAGES; j++) begin
        if (j < i) begin
          if (tuple_w[j].delay <= tuple_w[i].delay) c = c + 1'b1;
        end else if (j > i) begin
          if (tuple_w[j].delay < tuple_w[i].delay) c = c + 1'b1;
        end
      end
      rank_calc[i] = c[RANK_W-1:0];
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    ntpcf_pkg::ntpcf_tuple_t prev_t;
    logic [31:0]             inc_t;
    if (g == 0) begin : g_head
      assign prev_t = ctl.load ? samp_r : tuple_w[STAGES-1];
      assign inc_t  = '0;
    end else begin : g_body
      assign prev_t = tuple_w[g-1];
      assign inc_t  = inc_r;
    end
    ntpcf_cell #(.RANK_W(RANK_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_tuple (prev_t),
      .prev_rank  (rank_w[(g + STAGES - 1) % STAGES]),
      .age_inc    (inc_t),
      .rank_in    (rank_calc[g]),
      .tuple_o    (tuple_w[g]),
      .rank_o     (rank_w[g])
    );
  end

  // datapath helpers
  logic [48:0] inc_wide;
  logic [RANK_W-1:0] shamt;
  logic [48:0] diff, diff_abs;
  logic [ACC_W-1:0] acc_sh;
  logic [31:0] disp_out;
  logic [31:0] jit, floor_v;
  logic signed [6:0] fexp;
  logic [63:0] v, bitv, trial;
  logic [DIV_W-1:0] q;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0]   tdiv;
  logic [CNT_W:0]   den;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fresh_r;

  always_comb begin
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    samp_nxt       = samp_r;
    dt_nxt         = dt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    inc_nxt        = inc_r;
    last_used_nxt  = last_used_r;
    has_update_nxt = has_update_r;
    acc_nxt        = acc_r;
    best_off_nxt   = best_off_r;
    best_delay_nxt = best_delay_r;
    best_time_nxt  = best_time_r;
    mag_nxt        = mag_r;
    mv_nxt         = 1'b0;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    sum_nxt        = sum_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_fresh_nxt  = out_fresh_r;

    inc_wide = {1'b0, a_r[63:16]} + 49'((({32'd0, a_r[15:0]} << 16) + {1'b0, b_r}) >> 32);
    shamt    = RANK_W'(STAGES - 1) - head_rank;
    diff     = {head.offset[47], head.offset} - {best_off_r[47], best_off_r};
    diff_abs = diff[48] ? (49'd0 - diff) : diff;
    acc_sh   = acc_r >> STAGES;
    disp_out = (|acc_sh[ACC_W-1:32]) ? 32'hFFFF_FFFF : acc_sh[31:0];
    v        = sum_r[63:0];
    bitv     = 64'd1 << (7'd62 - {seq_r[5:0], 1'b0});
    trial    = res_r + bitv;
    q        = sum_r;
    rem      = rem_r;
    tdiv     = '0;
    den      = {1'b0, n_r} + 1'b1;
    fexp     = 7'(prec_r) + 7'sd16;
    if (fexp < 0) floor_v = '0;
    else if (fexp >= 7'sd32) floor_v = 32'hFFFF_FFFF;
    else floor_v = 32'd1 << fexp[4:0];
    jit = (res_r[31:0] < floor_v) ? floor_v : res_r[31:0];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // squared offsets land in the sum after passing through mag_r and sq_r
    if (sv_r) sum_nxt = sum_r + DIV_W'(sq_r);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          samp_nxt.offset = signed'(in_tdata[47:0]);
          samp_nxt.delay  = in_tdata[79:48];
          samp_nxt.disp   = in_tdata[111:80];
          samp_nxt.stime  = in_tdata[159:112];
          dt_nxt = (in_tdata[159:112] > last_used_r) ? in_tdata[159:112] - last_used_r
                                                     : '0;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        a_nxt     = drift_r * dt_r[47:16];
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        b_nxt     = {16'd0, drift_r} * {32'd0, dt_r[15:0]};
        state_nxt = ST_INC;
      end
      ST_INC: begin
        inc_nxt   = (|inc_wide[48:32]) ? 32'hFFFF_FFFF : inc_wide[31:0];
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        acc_nxt   = '0;
        sum_nxt   = '0;
        n_nxt     = '0;
        rem_nxt   = '0;
        res_nxt   = '0;
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        seq_nxt   = '0;
        state_nxt = ST_SCAN1;
      end
      ST_SCAN1: begin
        // weighted dispersion; grab the lowest-delay stage as it passes
        acc_nxt = acc_r + (ACC_W'(head.disp) << shamt);
        if (head_rank == '0) begin
          best_off_nxt   = head.offset;
          best_delay_nxt = head.delay;
          best_time_nxt  = head.stime;
        end
        if (seq_r == SEQ_W'(STAGES - 1)) begin
          seq_nxt   = '0;
          state_nxt = ST_SCAN2;
        end else begin
          seq_nxt = seq_r + 1'b1;
        end
      end
      ST_SCAN2: begin
        if (seq_r < SEQ_W'(STAGES)) begin
          mag_nxt = diff_abs[48] ? 32'hFFFF_FFFF : diff_abs[47:16];
          if ((head_rank != '0) && (head.disp < maxd_r)) begin
            mv_nxt = 1'b1;
            n_nxt  = n_r + 1'b1;
          end
        end
        if (seq_r == SEQ_W'(STAGES + 1)) begin
          seq_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          seq_nxt = seq_r + 1'b1;
        end
      end
      ST_DIV: begin
        // four quotient bits per cycle, dividend shifting out at the top
        for (int k = 0; k < 4; k++) begin
          tdiv = {rem, q[DIV_W-1]};
          q    = {q[DIV_W-2:0], 1'b0};
          if (tdiv >= den) begin
            tdiv = tdiv - den;
            q[0] = 1'b1;
          end
          rem = tdiv[CNT_W-1:0];
        end
        sum_nxt = q;
        rem_nxt = rem;
        if (seq_r == SEQ_W'(DIV_STEPS - 1)) begin
          seq_nxt   = '0;
          state_nxt = ST_SQRT;
        end else begin
          seq_nxt = seq_r + 1'b1;
        end
      end
      ST_SQRT: begin
        if (v >= trial) begin
          sum_nxt = {sum_r[DIV_W-1:64], v - trial};
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        if (seq_r == SEQ_W'(SQRT_STEPS - 1)) begin
          seq_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          seq_nxt = seq_r + 1'b1;
        end
      end
      ST_OUT: begin
        // hold until the previous beat has left the output register
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {jit, disp_out, best_delay_r, best_off_r};
          if (has_update_r && (best_time_r <= last_used_r)) begin
            out_fresh_nxt = 1'b0;
          end else begin
            out_fresh_nxt  = 1'b1;
            last_used_nxt  = best_time_r;
            has_update_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seq_r        <= '0;
      last_used_r  <= '0;
      has_update_r <= 1'b0;
      mv_r         <= 1'b0;
      sv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seq_r        <= seq_nxt;
      last_used_r  <= last_used_nxt;
      has_update_r <= has_update_nxt;
      mv_r         <= mv_nxt;
      sv_r         <= mv_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r       <= samp_nxt;
    dt_r         <= dt_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    inc_r        <= inc_nxt;
    acc_r        <= acc_nxt;
    best_off_r   <= best_off_nxt;
    best_delay_r <= best_delay_nxt;
    best_time_r  <= best_time_nxt;
    mag_r        <= mag_nxt;
    sq_r         <= mag_r * mag_r;
    n_r          <= n_nxt;
    rem_r        <= rem_nxt;
    sum_r        <= sum_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
    out_fresh_r  <= out_fresh_nxt;
  end

endmodule

[design/ntpcf_cell.sv]
module ntpcf_cell #(
  parameter int RANK_W = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ntpcf_pkg::ntpcf_cell_ctl_t ctl,
  input  ntpcf_pkg::ntpcf_tuple_t prev_tuple,
  input  logic [RANK_W-1:0]      prev_rank,
  input  logic [31:0]            age_inc,
  input  logic [RANK_W-1:0]      rank_in,
  output ntpcf_pkg::ntpcf_tuple_t tuple_o,
  output logic [RANK_W-1:0]      rank_o
);

  ntpcf_pkg::ntpcf_tuple_t tuple_r, tuple_nxt;
  logic [RANK_W-1:0]       rank_r, rank_nxt;
  logic [32:0]             aged;

  always_comb begin
    aged      = {1'b0, prev_tuple.disp} + {1'b0, age_inc};
    tuple_nxt = tuple_r;
    rank_nxt  = rank_r;
    if (ctl.load) begin
      tuple_nxt      = prev_tuple;
      // saturate the aged dispersion
      tuple_nxt.disp = aged[32] ? 32'hFFFF_FFFF : aged[31:0];
    end else if (ctl.rotate) begin
      tuple_nxt = prev_tuple;
      rank_nxt  = prev_rank;
    end else if (ctl.rank_we) begin
      rank_nxt = rank_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuple_r.offset <= '0;
      tuple_r.delay  <= ntpcf_pkg::MAX_DISP_RESET;
      tuple_r.disp   <= ntpcf_pkg::MAX_DISP_RESET;
      tuple_r.stime  <= '0;
    end else begin
      tuple_r <= tuple_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
  end

  assign tuple_o = tuple_r;
  assign rank_o  = rank_r;

endmodule

[sim/ntp_clock_filter_tb.sv]
`timescale 1ns / 100ps

module ntp_clock_filter_tb;

  localparam int NSTG = 8;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [47:0] offset;
    logic [31:0] delay;
    logic [31:0] disp;
    logic [47:0] stime;
  } sample_t;

  typedef struct packed {
    logic [47:0] offset;
    logic [31:0] delay;
    logic [31:0] disp;
    logic [31:0] jitter;
    logic        fresh;
  } filt_out_t;

  // One directed row: sample plus an optional hand-typed expectation
  typedef struct {
    sample_t   smp;
    bit        typed;
    filt_out_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;

  always #2 clk = ~clk;

  ntp_clock_filter #(.STAGES(NSTG)) DUT (.*);

  // Predictor state: filter stages and registers
  logic [63:0] m_drift, m_maxd, m_last;
  int          m_prec;
  bit          m_upd;
  logic [63:0] s_off[NSTG], s_dly[NSTG], s_dsp[NSTG], s_tim[NSTG];

  filt_out_t expected_q[$];
  int        mismatches = 0;
  bit        quiet_in = 0, quiet_out = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic filter_reset();
    m_drift = ntpcf_pkg::DRIFT_RESET;
    m_prec  = -18;
    m_maxd  = ntpcf_pkg::MAX_DISP_RESET;
    for (int i = 0; i < NSTG; i++) begin
      s_off[i] = 0; s_dly[i] = m_maxd; s_dsp[i] = m_maxd; s_tim[i] = 0;
    end
    m_last = 0;
    m_upd  = 0;
  endtask

  // Shift a sample in, rank by delay, and return the filter result
  function automatic filt_out_t filter_sample(sample_t sm);
    logic [63:0] dt, hi, lo, a, b, inc, nd, acc, mean, jit, fl;
    logic [127:0] ssum;
    logic [63:0] ax, bx, diff, mag;
    int rank[NSTG];
    int j, k, n, e;
    filt_out_t r;
    dt = (sm.stime > m_last) ? sm.stime - m_last : 0;
    hi = (dt >> 16) & M32;
    lo = dt & 64'hFFFF;
    a = m_drift * hi;
    b = m_drift * lo;
    inc = (a >> 16) + ((((a & 64'hFFFF) << 16) + b) >> 32);
    if (inc > M32) inc = M32;
    for (int i = NSTG - 1; i > 0; i--) begin
      nd = s_dsp[i-1] + inc;
      s_off[i] = s_off[i-1]; s_dly[i] = s_dly[i-1]; s_tim[i] = s_tim[i-1];
      s_dsp[i] = (nd > M32) ? M32 : nd;
    end
    s_off[0] = sm.offset; s_dly[0] = sm.delay; s_dsp[0] = sm.disp; s_tim[0] = sm.stime;
    // stable insertion sort: newer stage wins a tie
    for (int i = 0; i < NSTG; i++) begin
      j = i;
      while (j > 0 && s_dly[rank[j-1]] > s_dly[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    acc = 0;
    for (int i = 0; i < NSTG; i++) acc += s_dsp[rank[i]] << (NSTG - 1 - i);
    acc >>= NSTG;
    if (acc > M32) acc = M32;
    ssum = 0;
    n = 0;
    for (int i = 1; i < NSTG; i++) begin
      k = rank[i];
      if (s_dsp[k] < m_maxd) begin
        ax = {{16{s_off[k][47]}}, s_off[k][47:0]};
        bx = {{16{s_off[rank[0]][47]}}, s_off[rank[0]][47:0]};
        diff = ax - bx;
        mag = diff[63] ? -diff : diff;
        mag >>= 16;
        if (mag > M32) mag = M32;
        ssum += mag * mag;
        n++;
      end
    end
    mean = 64'(ssum / (n + 1));
    jit = isqrt(mean);
    if (jit > M32) jit = M32;
    e = m_prec + 16;
    fl = (e < 0) ? 0 : (e >= 32) ? M32 : (64'd1 << e);
    if (jit < fl) jit = fl;
    r.offset = s_off[rank[0]][47:0];
    r.delay  = s_dly[rank[0]][31:0];
    r.disp   = acc[31:0];
    r.jitter = jit[31:0];
    if (m_upd && s_tim[rank[0]] <= m_last) begin
      r.fresh = 0;
    end else begin
      r.fresh = 1;
      m_last = s_tim[rank[0]];
      m_upd = 1;
    end
    return r;
  endfunction

  task automatic write_reg(ntpcf_pkg::ntpcf_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ntpcf_pkg::REG_DRIFT_RATE: m_drift = val;
      ntpcf_pkg::REG_PRECISION:  m_prec = $signed(val[5:0]);
      ntpcf_pkg::REG_MAX_DISP:   m_maxd = val;
      default: ;
    endcase
  endtask

  // Send one beat; the expectation is queued at acceptance. Valid stays up
  // after acceptance until the next idle gap, the next beat or a drain.
  task automatic send_sample(sample_t sm, bit typed, filt_out_t want);
    filt_out_t p;
    while (!quiet_in && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sm.stime, sm.disp, sm.delay, sm.offset};
    do @(posedge clk); while (!in_tready);
    p = filter_sample(sm);
    if (typed && p != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: %h vs %h", want, p);
    end
    expected_q.push_back(p);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(logic [47:0] tbase);
    sample_t s;
    s.offset = {$urandom, $urandom} & M48;
    if ($urandom_range(3) != 0) s.offset = 48'($signed(32'($urandom)) >>> $urandom_range(31));
    s.delay  = $urandom_range(3) == 0 ? $urandom : $urandom_range(200000);
    s.disp   = $urandom_range(3) == 0 ? $urandom : $urandom_range(70000);
    s.stime  = $urandom_range(7) == 0 ? {$urandom, $urandom} & M48
             : tbase + $urandom_range(300000) - 20000;
    return s;
  endfunction

  // Output side: stall at random, check each accepted beat
  always @(posedge clk) begin
    filt_out_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[47:0], out_tdata[79:48], out_tdata[111:80],
               out_tdata[143:112], out_tuser};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: off %h/%h dly %h/%h disp %h/%h jit %h/%h fresh %b/%b",
                       exp_r.offset, got.offset, exp_r.delay, got.delay, exp_r.disp,
                       got.disp, exp_r.jitter, got.jitter, exp_r.fresh, got.fresh);
          end
        end
      end
      out_tready <= quiet_out || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    #4000000;
    $display("ntp_clock_filter_tb: FAIL");
    $finish;
  end

  initial begin
    dir_row_t tbl[$];
    dir_row_t row;
    filt_out_t none;
    logic [47:0] tb;
    none = '0;
    filter_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First sample after reset: all other stages empty, jitter at floor 0
    row.smp = '{48'd5, 32'd100, 32'd10, 48'd1000};
    row.typed = 1;
    row.want = '{48'd5, 32'd100, 32'd520197, 32'd0, 1'b1};
    tbl.push_back(row);
    row.typed = 0;
    // extremes of offset, delay, dispersion and time
    row.smp = '{48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF};
    tbl.push_back(row);
    row.smp = '{48'h8000_0000_0000, 32'd0, 32'd0, 48'd0}; // time going backwards
    tbl.push_back(row);
    row.smp = '{48'h8000_0000_0000, 32'd0, 32'd0, 48'd0}; // delay tie, stale best
    tbl.push_back(row);
    row.smp = '{48'h7FFF_FFFF_FFFF, 32'd0, 32'd5, 48'hFFFF_FFFF_FFFF};
    tbl.push_back(row);
    for (int i = 0; i < 10; i++) begin
      row.smp = '{48'(i * 65536 * 3 - 100000), 32'(50 + (i % 3)), 32'(i * 7),
                  48'hFFFF_FFFF_FFFF};
      tbl.push_back(row);
    end
    foreach (tbl[i]) send_sample(tbl[i].smp, tbl[i].typed, tbl[i].want);
    drain();

    // Walk several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(ntpcf_pkg::REG_DRIFT_RATE, 32'hFFFF_FFFF);
          write_reg(ntpcf_pkg::REG_PRECISION, 32'(-31));
          write_reg(ntpcf_pkg::REG_MAX_DISP, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(ntpcf_pkg::REG_DRIFT_RATE, 32'd0);
          write_reg(ntpcf_pkg::REG_PRECISION, 32'd0);
          write_reg(ntpcf_pkg::REG_MAX_DISP, 32'd0);
        end
        2: begin
          write_reg(ntpcf_pkg::REG_DRIFT_RATE, $urandom);
          write_reg(ntpcf_pkg::REG_PRECISION, 32'(-$urandom_range(31)));
          write_reg(ntpcf_pkg::REG_MAX_DISP, $urandom_range(2000000));
        end
        3: begin
          write_reg(ntpcf_pkg::REG_DRIFT_RATE, 32'd64425);
          write_reg(ntpcf_pkg::REG_PRECISION, 32'(-16));
          write_reg(ntpcf_pkg::REG_MAX_DISP, 32'd1048576);
        end
        default: begin
          write_reg(ntpcf_pkg::REG_DRIFT_RATE, 32'h8000_0000);
          write_reg(ntpcf_pkg::REG_PRECISION, 32'(-1));
          write_reg(ntpcf_pkg::REG_MAX_DISP, 32'd200000);
        end
      endcase
      quiet_in = (ph == 3);
      quiet_out = (ph == 3);
      tb = {$urandom, $urandom} & 48'h0000_FFFF_FFFF;
      for (int i = 0; i < 200; i++) begin
        tb += $urandom_range(200000);
        send_sample(rand_sample(tb), 0, none);
      end
      drain();
      quiet_in = 0;
      quiet_out = 0;
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ntp_clock_filter_tb: PASS");
    end else begin
      $display("ntp_clock_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
